// File: rtl/jbmc_pkg.sv
package jbmc_pkg;

    // marker and code bytes
    localparam logic [7:0] MARK_FF   = 8'hFF;
    localparam logic [7:0] CODE_SOI  = 8'hD8;
    localparam logic [7:0] CODE_EOI  = 8'hD9;
    localparam logic [7:0] CODE_DQT  = 8'hDB;
    localparam logic [7:0] CODE_DHT  = 8'hC4;
    localparam logic [7:0] CODE_DRI  = 8'hDD;
    localparam logic [7:0] CODE_SOF0 = 8'hC0;
    localparam logic [7:0] CODE_SOF1 = 8'hC1;
    localparam logic [7:0] CODE_SOF2 = 8'hC2;
    localparam logic [7:0] CODE_SOS  = 8'hDA;

    // smallest legal segment length (the length field counts itself)
    localparam logic [15:0] LEN_FIELD = 16'd2;

    typedef enum logic [1:0] {
        V_PENDING = 2'd0,
        V_ACCEPT  = 2'd1,
        V_REJECT  = 2'd2,
        V_EARLIER = 2'd3
    } t_verdict;

    typedef enum logic [7:0] {
        PH_FIRST_FF = 8'b0000_0001,
        PH_SOI      = 8'b0000_0010,
        PH_MARK_FF  = 8'b0000_0100,
        PH_CODE     = 8'b0000_1000,
        PH_LEN_HI   = 8'b0001_0000,
        PH_LEN_LO   = 8'b0010_0000,
        PH_SKIP     = 8'b0100_0000,
        PH_DONE     = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  len_hi;
        logic [15:0] skip;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:  PH_FIRST_FF,
        len_hi: 8'd0,
        skip:   16'd0
    };

endpackage

// File: rtl/jbmc_byte_if.sv
interface jbmc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// File: rtl/jbmc_verdict_if.sv
interface jbmc_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// File: rtl/jbmc_step.sv
module jbmc_step (
    input  jbmc_pkg::t_parse_state i_state,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_end_of_file,
    output jbmc_pkg::t_parse_state o_state,
    output jbmc_pkg::t_verdict     o_verdict
);

    jbmc_pkg::t_parse_state nxt;
    jbmc_pkg::t_verdict     vrd;
    logic [15:0]            seg_len;
    logic [15:0]            payload;
    logic [15:0]            skip_dec;

    assign seg_len  = {i_state.len_hi, i_data_byte};
    assign payload  = seg_len - jbmc_pkg::LEN_FIELD;
    assign skip_dec = i_state.skip - 16'd1;

    always_comb begin
        nxt = i_state;
        vrd = jbmc_pkg::V_PENDING;
        unique case (i_state.phase)
            jbmc_pkg::PH_FIRST_FF: begin
                if (i_data_byte == jbmc_pkg::MARK_FF) nxt.phase = jbmc_pkg::PH_SOI;
                else vrd = jbmc_pkg::V_REJECT;
            end
            jbmc_pkg::PH_SOI: begin
                if (i_data_byte == jbmc_pkg::CODE_SOI) nxt.phase = jbmc_pkg::PH_MARK_FF;
                else vrd = jbmc_pkg::V_REJECT;
            end
            jbmc_pkg::PH_MARK_FF: begin
                if (i_data_byte == jbmc_pkg::MARK_FF) nxt.phase = jbmc_pkg::PH_CODE;
                else vrd = jbmc_pkg::V_REJECT;
            end
            jbmc_pkg::PH_CODE: begin
                // dqt, dht, dri, sof0 and unknown codes all carry a length
                if (i_data_byte == jbmc_pkg::CODE_SOS) begin
                    vrd = jbmc_pkg::V_ACCEPT;
                end else if (i_data_byte == jbmc_pkg::CODE_EOI ||
                             i_data_byte == jbmc_pkg::CODE_SOF1 ||
                             i_data_byte == jbmc_pkg::CODE_SOF2) begin
                    vrd = jbmc_pkg::V_REJECT;
                end else begin
                    nxt.phase = jbmc_pkg::PH_LEN_HI;
                end
            end
            jbmc_pkg::PH_LEN_HI: begin
                nxt.len_hi = i_data_byte;
                nxt.phase  = jbmc_pkg::PH_LEN_LO;
            end
            jbmc_pkg::PH_LEN_LO: begin
                if (seg_len < jbmc_pkg::LEN_FIELD) begin
                    vrd = jbmc_pkg::V_REJECT;
                end else begin
                    nxt.skip  = payload;
                    nxt.phase = (payload == 16'd0) ? jbmc_pkg::PH_MARK_FF
                                                   : jbmc_pkg::PH_SKIP;
                end
            end
            jbmc_pkg::PH_SKIP: begin
                nxt.skip = skip_dec;
                if (skip_dec == 16'd0) nxt.phase = jbmc_pkg::PH_MARK_FF;
            end
            jbmc_pkg::PH_DONE: begin
                vrd = jbmc_pkg::V_EARLIER;
            end
            default: begin
                vrd = jbmc_pkg::V_EARLIER;
            end
        endcase

        if (vrd == jbmc_pkg::V_ACCEPT || vrd == jbmc_pkg::V_REJECT) begin
            nxt.phase = jbmc_pkg::PH_DONE;
        end

        // last byte of the file closes the decision and rearms the parser
        if (i_end_of_file) begin
            if (vrd == jbmc_pkg::V_PENDING) vrd = jbmc_pkg::V_REJECT;
            nxt = jbmc_pkg::PARSE_RESET;
        end
    end

    assign o_state   = nxt;
    assign o_verdict = vrd;

endmodule

// File: rtl/jpeg_baseline_marker_checker_core.sv
// baseline jpeg marker checker
// i_byte carries one file byte per word (data_byte, end_of_file); o_result
// carries one verdict word per input word, in order: 0 pending, 1 accepted
// at the sos code, 2 rejected at this byte, 3 decided at an earlier byte
// both channels are valid/ready; a word moves when both are high
// a word accepted on i_byte lands in the input register, is parsed there and
// its verdict is registered as the word moves on, valid from then on
// throughput: one byte per cycle unless o_result stalls, set by the single
// parse step between the input and verdict registers (the state update is a
// few byte compares, two parallel 16-bit subtracts and a one-hot phase move)
// a stalled o_result holds its verdict; the input register takes a word
// while it is empty or while its own word moves on (verdict slot free or
// draining in that cycle), so a stall lets one more word in and then
// i_byte.ready drops until the receiver takes the verdict
// reset (synchronous, active low) empties both registers and sets the parser
// to expect the opening ff byte; end_of_file on a byte rearms it the same way
module jpeg_baseline_marker_checker_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    jbmc_byte_if.sink              i_byte,
    jbmc_verdict_if.source         o_result
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;

    // verdict register
    logic               r_out_valid;
    jbmc_pkg::t_verdict r_out_verdict;

    // parser state, updated as each word leaves the input register
    jbmc_pkg::t_parse_state r_state;

    jbmc_pkg::t_parse_state n_state;
    jbmc_pkg::t_verdict     n_verdict;

    logic advance;
    logic take_in;

    // input word moves on when the verdict slot is empty or being drained
    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign take_in = i_byte.valid && i_byte.ready;

    assign i_byte.ready     = !r_in_valid || advance;
    assign o_result.valid   = r_out_valid;
    assign o_result.verdict = r_out_verdict;

    jbmc_step u_step (
        .i_state       (r_state),
        .i_data_byte   (r_in_byte),
        .i_end_of_file (r_in_eof),
        .o_state       (n_state),
        .o_verdict     (n_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= jbmc_pkg::PARSE_RESET;
        end else begin
            if (i_byte.ready) r_in_valid <= i_byte.valid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_byte <= i_byte.data_byte;
            r_in_eof  <= i_byte.end_of_file;
        end
        if (advance) r_out_verdict <= n_verdict;
    end

endmodule

// File: verif/tb_jpeg_baseline_marker_checker_core.sv
module tb_jpeg_baseline_marker_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import jbmc_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_WORDS = 1850;
    localparam int DRAIN_CYCLES = 16;

    logic i_clk;
    logic i_rst_n;

    jbmc_byte_if    byte_ch ();
    jbmc_verdict_if verdict_ch ();

    jpeg_baseline_marker_checker_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (verdict_ch)
    );

    // parser mirror, advanced once per accepted byte word
    t_phase      track_phase;
    logic [7:0]  track_len_hi;
    logic [15:0] track_skip;

    t_verdict   verdict_due [$];
    logic [7:0] file_bytes [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int live_words     = 0;
    int files_sent     = 0;
    int seen_accepts   = 0;
    int seen_rejects   = 0;
    int words_checked  = 0;
    int errors         = 0;
    int cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d verdict words outstanding",
                     $time, verdict_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // receiver backpressure, redrawn every falling edge
    initial begin
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            verdict_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void clear_tracker();
        track_phase  = PH_FIRST_FF;
        track_len_hi = 8'd0;
        track_skip   = 16'd0;
    endfunction

    // one parse step on the mirror; returns the verdict owed for this byte
    function automatic t_verdict parse_byte(logic [7:0] b, logic eof);
        t_verdict    v;
        logic [15:0] seg_len;
        v       = V_PENDING;
        seg_len = 16'd0;
        case (track_phase)
            PH_FIRST_FF: begin
                if (b == MARK_FF) track_phase = PH_SOI;
                else v = V_REJECT;
            end
            PH_SOI: begin
                if (b == CODE_SOI) track_phase = PH_MARK_FF;
                else v = V_REJECT;
            end
            PH_MARK_FF: begin
                if (b == MARK_FF) track_phase = PH_CODE;
                else v = V_REJECT;
            end
            PH_CODE: begin
                if (b == CODE_SOS) v = V_ACCEPT;
                else if (b == CODE_EOI || b == CODE_SOF1 || b == CODE_SOF2) v = V_REJECT;
                else track_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                track_len_hi = b;
                track_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_len = {track_len_hi, b};
                if (seg_len < LEN_FIELD) begin
                    v = V_REJECT;
                end else begin
                    track_skip  = seg_len - LEN_FIELD;
                    track_phase = (track_skip == 16'd0) ? PH_MARK_FF : PH_SKIP;
                end
            end
            PH_SKIP: begin
                track_skip = track_skip - 16'd1;
                if (track_skip == 16'd0) track_phase = PH_MARK_FF;
            end
            default: v = V_EARLIER;
        endcase
        if (v == V_ACCEPT || v == V_REJECT) track_phase = PH_DONE;
        // last byte of the file: undecided means rejected, then rearm
        if (eof) begin
            if (v == V_PENDING) v = V_REJECT;
            clear_tracker();
        end
        return v;
    endfunction

    // verdict checker
    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            words_checked++;
            if (verdict_due.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: verdict word %0d arrived with nothing expected",
                             $time, verdict_ch.verdict);
            end else begin
                want = verdict_due.pop_front();
                if (verdict_ch.verdict !== want) begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: verdict mismatch, expected %0d (%s) actual %0d",
                                 $time, want, want.name(), verdict_ch.verdict);
                end else if (want == V_ACCEPT) begin
                    seen_accepts++;
                end else if (want == V_REJECT) begin
                    seen_rejects++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        t_verdict v;
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.end_of_file <= eof;
        do @(posedge i_clk); while (!byte_ch.ready);
        v = parse_byte(b, eof);
        verdict_due.push_back(v);
        if (v != V_EARLIER) live_words++;
    endtask

    // whole file, end_of_file on its last byte
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // stop sending and let every owed verdict come out
    task automatic drain_verdicts();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (verdict_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic push_random_bytes(input int count);
        repeat (count) file_bytes.push_back(8'($urandom));
    endtask

    // mostly well-formed headers with random content, some noise and damage
    task automatic build_file();
        int          nseg;
        int          pick;
        logic [15:0] seg_len;
        logic [7:0]  code;
        bit          ended;
        file_bytes.delete();
        ended = 1'b0;
        if ($urandom_range(99) < 10) begin
            push_random_bytes($urandom_range(1, 6));
            if ($urandom_range(1)) file_bytes[0] = MARK_FF;
            return;
        end
        file_bytes.push_back(MARK_FF);
        file_bytes.push_back(CODE_SOI);
        nseg = $urandom_range(0, 4);
        for (int s = 0; s < nseg && !ended; s++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: code = CODE_DQT;
                2:    code = CODE_DHT;
                3:    code = CODE_DRI;
                4:    code = CODE_SOF0;
                5:    code = MARK_FF;
                default: begin
                    do code = 8'($urandom);
                    while (code == CODE_EOI || code == CODE_SOF1 || code == CODE_SOF2 ||
                           code == CODE_SOS);
                end
            endcase
            file_bytes.push_back(MARK_FF);
            file_bytes.push_back(code);
            pick = $urandom_range(0, 99);
            if (pick < 75)      seg_len = 16'($urandom_range(2, 10));
            else if (pick < 90) seg_len = 16'($urandom_range(2, 40));
            else if (pick < 94) seg_len = 16'($urandom_range(0, 1));
            else                seg_len = 16'($urandom);
            file_bytes.push_back(seg_len[15:8]);
            file_bytes.push_back(seg_len[7:0]);
            if (seg_len < LEN_FIELD) begin
                ended = 1'b1;
            end else if (seg_len > 16'd64) begin
                // long segment: file is cut short inside the payload
                push_random_bytes($urandom_range(0, 5));
                ended = 1'b1;
            end else begin
                push_random_bytes(seg_len - LEN_FIELD);
            end
        end
        if (!ended) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                file_bytes.push_back(MARK_FF);
                file_bytes.push_back(CODE_SOS);
                if ($urandom_range(1)) push_random_bytes($urandom_range(1, 4));
            end else if (pick < 75) begin
                file_bytes.push_back(MARK_FF);
                case ($urandom_range(2))
                    0:       file_bytes.push_back(CODE_EOI);
                    1:       file_bytes.push_back(CODE_SOF1);
                    default: file_bytes.push_back(CODE_SOF2);
                endcase
            end else if (pick < 85) begin
                push_random_bytes(1);
            end
        end
        if ($urandom_range(99) < 12)
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
        if ($urandom_range(99) < 8 && file_bytes.size() > 1) begin
            pick = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > pick) void'(file_bytes.pop_back());
        end
    endtask

    // bad first byte, bad start code, missing marker byte
    task automatic test_header_faults();
        file_bytes = '{8'h00};
        send_file();
        file_bytes = '{MARK_FF, 8'h00};
        send_file();
        file_bytes = '{MARK_FF, CODE_SOI, 8'h12};
        send_file();
    endtask

    // end of image, progressive and extended frames, scan start on the last byte,
    // bytes after a decision
    task automatic test_marker_codes();
        file_bytes = '{MARK_FF, CODE_SOI, MARK_FF, CODE_EOI, 8'h77, 8'hFF};
        send_file();
        file_bytes = '{MARK_FF, CODE_SOI, MARK_FF, CODE_SOF1};
        send_file();
        file_bytes = '{MARK_FF, CODE_SOI, MARK_FF, CODE_SOF2};
        send_file();
        file_bytes = '{MARK_FF, CODE_SOI, MARK_FF, CODE_SOS};
        send_file();
    endtask

    // fill code with zero length, length one, bare length field, file ending early
    task automatic test_segment_lengths();
        file_bytes = '{MARK_FF, CODE_SOI, MARK_FF, MARK_FF, 8'h00, 8'h00};
        send_file();
        file_bytes = '{MARK_FF, CODE_SOI, MARK_FF, CODE_DHT, 8'h00, 8'h01};
        send_file();
        file_bytes = '{MARK_FF, CODE_SOI, MARK_FF, CODE_DRI, 8'h00, 8'h02,
                       MARK_FF, CODE_SOF0, 8'h00, 8'h03, 8'hAB, MARK_FF};
        send_file();
    endtask

    // random files under four idling patterns, draining between them
    task automatic test_random_files();
        int send_pct [4] = '{0, 85, 0, 21};
        int recv_pct [4] = '{0, 0, 85, 21};
        int start;
        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = send_pct[m];
            recv_stall_pct = recv_pct[m];
            start = live_words;
            while (live_words - start < RANDOM_WORDS / 4) begin
                build_file();
                send_file();
            end
            drain_verdicts();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'd0;
        byte_ch.end_of_file = 1'b0;
        i_rst_n             = 1'b0;
        clear_tracker();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_header_faults();
        test_marker_codes();
        test_segment_lengths();
        test_random_files();

        drain_verdicts();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (verdict_due.size() != 0) begin
            errors++;
            $display("%0t: %0d verdict words never arrived", $time, verdict_due.size());
        end

        $display("checked %0d verdict words from %0d files (%0d accepted, %0d rejected)",
                 words_checked, files_sent, seen_accepts, seen_rejects);
        $display("idling patterns: none, sender gaps, receiver stalls, both; %0d errors",
                 errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: jpeg_baseline_marker_checker_core.f
rtl/jbmc_pkg.sv
rtl/jbmc_byte_if.sv
rtl/jbmc_verdict_if.sv
rtl/jbmc_step.sv
rtl/jpeg_baseline_marker_checker_core.sv
verif/tb_jpeg_baseline_marker_checker_core.sv
